FILE: rtl/core/gdd_pkg.sv
// gdd_pkg: shared types and constants of the grid diffusion and decay engine
// holds payload structs, function codes, register indexes and sequencer states
// no dependencies
`timescale 1ns / 1ps

package gdd_pkg;

    // grid geometry
    localparam int GRID_X    = 64;
    localparam int GRID_Y    = 64;
    localparam int NUM_TYPES = 2;
    localparam int X_BITS    = 6;
    localparam int Y_BITS    = 6;
    localparam int T_BITS    = 1;
    localparam int CELL_BITS = X_BITS + Y_BITS;
    localparam int ADDR_BITS = T_BITS + CELL_BITS;
    localparam int VAL_W     = 17;

    localparam logic [VAL_W-1:0] Q_ONE = 17'h10000;

    // request function codes
    typedef enum logic [1:0] {
        FUNC_SRC  = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DIFF  = 2'd0,
        CFG_DECAY = 2'd1,
        CFG_ITER  = 2'd2,
        CFG_NONE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [X_BITS-1:0] x_pos;
        logic [Y_BITS-1:0] y_pos;
        logic [T_BITS-1:0] cell_type;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             done_res;
    } out_item_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRC,
        ST_RD,
        ST_RDWAIT,
        ST_TAP,
        ST_TAP_LAST,
        ST_LAP,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_RESP
    } state_t;

endpackage

FILE: rtl/core/gdd_ram.sv
// gdd_ram: simple dual port memory, one write and one registered read per cycle
// depends on nothing
`timescale 1ns / 1ps

module gdd_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 17
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/grid_diffusion_decay_engine_top.sv
// Grid diffusion and decay engine. Keeps one 64 x 64 concentration grid per neuron type
// (two types) in a single-port-write memory, Q1.16 cells from 0 to 1.0. After reset a
// clearing pass writes zero to all 8192 cells, one per cycle, while no request is taken.
// A tick runs iteration_count sweeps; each sweep, per type, visits every interior cell
// in turn (five reads through the one grid read port, then the shared multiplier twice
// and a saturating sum into the scratch grid) and then copies the scratch grid back to
// the interior cells, one read and one write per cell.
// One request is in flight at a time; its result waits in an output register.
// depends on gdd_pkg and gdd_ram
`timescale 1ns / 1ps

module grid_diffusion_decay_engine_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gdd_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gdd_pkg::out_item_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import gdd_pkg::*;

    state_t state_reg, state_next;

    logic [14:0]          diff_reg;
    logic [15:0]          decay_reg;
    logic [9:0]           iter_cfg_reg;

    logic [X_BITS-1:0]    x_reg;
    logic [Y_BITS-1:0]    y_reg;
    logic [T_BITS-1:0]    t_reg;
    logic [9:0]           iter_reg;
    logic [2:0]           tap_reg;
    logic [ADDR_BITS-1:0] clr_reg;

    logic [VAL_W-1:0]     old_reg;
    logic [18:0]          nsum_reg;
    logic signed [19:0]   lap_reg;
    logic signed [36:0]   p1_reg;
    logic signed [36:0]   p2_reg;

    logic [VAL_W-1:0]     res_value_reg;
    logic                 res_done_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    // memory controls
    logic                 conc_we;
    logic [ADDR_BITS-1:0] conc_waddr;
    logic [VAL_W-1:0]     conc_wdata;
    logic [ADDR_BITS-1:0] conc_raddr;
    logic [VAL_W-1:0]     conc_rdata;
    logic                 next_we;
    logic [CELL_BITS-1:0] next_waddr;
    logic [CELL_BITS-1:0] next_raddr;
    logic [VAL_W-1:0]     next_rdata;

    logic                 accept;
    logic                 in_grid;
    logic                 out_load;
    logic                 x_last;
    logic                 y_last;
    logic                 t_last;
    logic                 iter_last;
    logic [CELL_BITS-1:0] cell_idx;
    logic [CELL_BITS-1:0] tap_idx;

    logic signed [16:0]   mul_a;
    logic signed [19:0]   mul_b;
    logic signed [36:0]   mul_p;
    logic signed [39:0]   sum;
    logic [23:0]          rnd;
    logic [VAL_W-1:0]     new_val;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign in_grid   = ({1'b0, s_data.x_pos} < (X_BITS+1)'(GRID_X))
                    && ({1'b0, s_data.y_pos} < (Y_BITS+1)'(GRID_Y))
                    && ({1'b0, s_data.cell_type} < (T_BITS+1)'(NUM_TYPES));
    assign out_load  = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    assign x_last    = (x_reg == X_BITS'(GRID_X - 2));
    assign y_last    = (y_reg == Y_BITS'(GRID_Y - 2));
    assign t_last    = (t_reg == T_BITS'(NUM_TYPES - 1));
    assign iter_last = ((iter_reg + 10'd1) == iter_cfg_reg);
    assign cell_idx  = {y_reg, x_reg};

    // stencil tap address: center, west, east, north, south
    always_comb begin
        unique case (tap_reg)
            3'd0:    tap_idx = cell_idx;
            3'd1:    tap_idx = cell_idx - CELL_BITS'(1);
            3'd2:    tap_idx = cell_idx + CELL_BITS'(1);
            3'd3:    tap_idx = cell_idx - CELL_BITS'(GRID_X);
            default: tap_idx = cell_idx + CELL_BITS'(GRID_X);
        endcase
    end

    // shared multiplier: rate times laplacian, then decay times old
    assign mul_a = (state_reg == ST_MUL_A) ? $signed({2'b00, diff_reg})
                                           : $signed({1'b0, decay_reg});
    assign mul_b = (state_reg == ST_MUL_A) ? lap_reg : $signed({3'b000, old_reg});
    assign mul_p = mul_a * mul_b;

    // saturating cell update
    always_comb begin
        sum = $signed({7'd0, old_reg, 16'd0})
            + $signed({{3{p1_reg[36]}}, p1_reg})
            - $signed({{3{p2_reg[36]}}, p2_reg})
            + 40'sd32768;
        rnd = sum[39:16];
        if (sum[39]) begin
            new_val = '0;
        end else if (rnd > 24'd65536) begin
            new_val = Q_ONE;
        end else begin
            new_val = rnd[VAL_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    priority if (s_data.func == FUNC_SRC && in_grid) begin
                        state_next = ST_SRC;
                    end else if (s_data.func == FUNC_READ && in_grid) begin
                        state_next = ST_RD;
                    end else if (s_data.func == FUNC_TICK && iter_cfg_reg != 10'd0) begin
                        state_next = ST_TAP;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SRC:      state_next = ST_RESP;
            ST_RD:       state_next = ST_RDWAIT;
            ST_RDWAIT:   state_next = ST_RESP;
            ST_TAP: begin
                if (tap_reg == 3'd4) state_next = ST_TAP_LAST;
            end
            ST_TAP_LAST: state_next = ST_LAP;
            ST_LAP:      state_next = ST_MUL_A;
            ST_MUL_A:    state_next = ST_MUL_B;
            ST_MUL_B:    state_next = ST_SUM;
            ST_SUM:      state_next = (x_last && y_last) ? ST_COPY_RD : ST_TAP;
            ST_COPY_RD:  state_next = ST_COPY_WR;
            ST_COPY_WR: begin
                if (!(x_last && y_last)) begin
                    state_next = ST_COPY_RD;
                end else if (t_last && iter_last) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_TAP;
                end
            end
            ST_RESP: begin
                if (out_load) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        conc_we    = 1'b0;
        conc_waddr = {t_reg, cell_idx};
        conc_wdata = next_rdata;
        conc_raddr = {t_reg, tap_idx};
        next_we    = 1'b0;
        next_waddr = cell_idx;
        next_raddr = cell_idx;
        unique case (state_reg)
            ST_CLEAR: begin
                conc_we    = 1'b1;
                conc_waddr = clr_reg;
                conc_wdata = '0;
            end
            ST_SRC: begin
                conc_we    = 1'b1;
                conc_wdata = Q_ONE;
            end
            ST_RD:      conc_raddr = {t_reg, cell_idx};
            ST_SUM:     next_we = 1'b1;
            ST_COPY_WR: conc_we = 1'b1;
            default: ;
        endcase
    end

    // sequencer state and clearing counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + ADDR_BITS'(1);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_reg     <= 15'd6554;
            decay_reg    <= 16'd66;
            iter_cfg_reg <= 10'd150;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DIFF:  diff_reg     <= cfg_data[14:0];
                CFG_DECAY: decay_reg    <= cfg_data;
                CFG_ITER:  iter_cfg_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // scan counters and arithmetic registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                tap_reg       <= 3'd0;
                iter_reg      <= 10'd0;
                res_value_reg <= '0;
                if (s_data.func == FUNC_TICK) begin
                    x_reg        <= X_BITS'(1);
                    y_reg        <= Y_BITS'(1);
                    t_reg        <= '0;
                    res_done_reg <= 1'b1;
                end else begin
                    x_reg        <= s_data.x_pos;
                    y_reg        <= s_data.y_pos;
                    t_reg        <= s_data.cell_type;
                    res_done_reg <= in_grid && (s_data.func != FUNC_NONE);
                end
            end
            ST_RDWAIT: res_value_reg <= conc_rdata;
            ST_TAP: begin
                tap_reg <= tap_reg + 3'd1;
                if (tap_reg == 3'd0) begin
                    nsum_reg <= '0;
                end else if (tap_reg == 3'd1) begin
                    old_reg <= conc_rdata;
                end else begin
                    nsum_reg <= nsum_reg + {2'b00, conc_rdata};
                end
            end
            ST_TAP_LAST: begin
                tap_reg  <= 3'd0;
                nsum_reg <= nsum_reg + {2'b00, conc_rdata};
            end
            ST_LAP:   lap_reg <= $signed({1'b0, nsum_reg}) - $signed({1'b0, old_reg, 2'b00});
            ST_MUL_A: p1_reg  <= mul_p;
            ST_MUL_B: p2_reg  <= mul_p;
            ST_SUM, ST_COPY_WR: begin
                if (!x_last) begin
                    x_reg <= x_reg + X_BITS'(1);
                end else begin
                    x_reg <= X_BITS'(1);
                    y_reg <= y_last ? Y_BITS'(1) : y_reg + Y_BITS'(1);
                    if (y_last && state_reg == ST_COPY_WR) begin
                        t_reg <= t_last ? '0 : t_reg + T_BITS'(1);
                        if (t_last) iter_reg <= iter_reg + 10'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.value    <= res_value_reg;
            m_data_reg.done_res <= res_done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // concentration grids of all types
    gdd_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (VAL_W)
    ) u_conc_ram (
        .aclk  (aclk),
        .we    (conc_we),
        .waddr (conc_waddr),
        .wdata (conc_wdata),
        .raddr (conc_raddr),
        .rdata (conc_rdata)
    );

    // scratch grid of one sweep
    gdd_ram #(
        .ADDR_W (CELL_BITS),
        .DATA_W (VAL_W)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (new_val),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

endmodule

FILE: rtl/core/gdd_checker.sv
// gdd_checker: port level checks of the grid diffusion and decay engine
// depends on gdd_pkg; bound to grid_diffusion_decay_engine_top
`timescale 1ns / 1ps

module gdd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input gdd_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input gdd_pkg::out_item_t m_data
);
    import gdd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // concentration never exceeds one
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.value <= Q_ONE)
        else $error("value above 1.0");

    // a request not carried out returns zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.done_res |-> m_data.value == '0)
        else $error("nonzero value on failed request");

endmodule

bind grid_diffusion_decay_engine_top gdd_checker u_gdd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
